// ===== rtl/core/fsd_pkg.sv =====
// Shared types and constants for the byte-stuffing frame decoder.
// No dependencies; imported by every module of the block.
package fsd_pkg;

    localparam int BYTE_W           = 8;
    localparam int IDX_W            = 6;
    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int CFG_AW           = 2;

    localparam logic [BYTE_W-1:0] START_FLAG_RST  = 8'hF7;
    localparam logic [BYTE_W-1:0] END_FLAG_RST    = 8'h7F;
    localparam logic [BYTE_W-1:0] ESCAPE_FLAG_RST = 8'h7D;

    typedef enum logic [CFG_AW-1:0] {
        REG_START_FLAG  = 2'd0,
        REG_END_FLAG    = 2'd1,
        REG_ESCAPE_FLAG = 2'd2
    } cfg_reg_t;

    // Completed-frame descriptor handed from the front end to the queue
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] len;
    } fsd_push_t;

endpackage

// ===== rtl/core/fsd_front.sv =====
// Front end: flag registers, byte classification, payload store writes.
// Depends on fsd_pkg.
module fsd_front
    import fsd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int AW           = $clog2(BUFFER_DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              wr_bank,
    output logic              wr_en,
    output logic [AW:0]       wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output fsd_push_t         push_desc
);

    typedef enum logic [1:0] {ST_IDLE, ST_RECV, ST_ESC} state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  fill_reg, fill_next;
    logic              bank_reg, bank_next;
    logic [BYTE_W-1:0] start_flag_reg, end_flag_reg, escape_flag_reg;
    logic              store;
    logic              overflow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_flag_reg  <= START_FLAG_RST;
            end_flag_reg    <= END_FLAG_RST;
            escape_flag_reg <= ESCAPE_FLAG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_START_FLAG:  start_flag_reg  <= cfg_wdata;
                REG_END_FLAG:    end_flag_reg    <= cfg_wdata;
                REG_ESCAPE_FLAG: escape_flag_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign overflow = ({1'b0, fill_reg} + 1'b1) >= (IDX_W+1)'(BUFFER_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bank_next  = bank_reg;
        store      = 1'b0;
        push_desc  = '{valid: 1'b0, len: fill_reg};
        if (accept)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (rx_byte == start_flag_reg)
                    begin
                        state_next = ST_RECV;
                        fill_next  = '0;
                    end
                end
                ST_ESC:
                begin
                    store = 1'b1;
                end
                ST_RECV:
                begin
                    if (rx_byte == end_flag_reg)
                    begin
                        // hand the frame to the back end, move to the other bank
                        state_next      = ST_IDLE;
                        push_desc.valid = 1'b1;
                        bank_next       = ~bank_reg;
                    end
                    else if (rx_byte == escape_flag_reg)
                        state_next = ST_ESC;
                    else
                        store = 1'b1;
                end
                default: state_next = ST_IDLE;
            endcase
            if (store)
            begin
                if (overflow)
                begin
                    // drop the frame silently
                    state_next = ST_IDLE;
                    fill_next  = '0;
                    store      = 1'b0;
                end
                else
                begin
                    state_next = ST_RECV;
                    fill_next  = IDX_W'(fill_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bank_reg  <= bank_next;
        end
    end

    assign wr_bank = bank_reg;
    assign wr_en   = store;
    assign wr_addr = {bank_reg, fill_reg[AW-1:0]};
    assign wr_data = rx_byte;

endmodule

// ===== rtl/core/fsd_queue.sv =====
// Two-entry descriptor queue, one entry per payload bank.
// Depends on fsd_pkg.
module fsd_queue
    import fsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_bank,
    input  fsd_push_t        push_desc,
    input  logic             rel,
    input  logic             rel_bank,
    output logic [1:0]       desc_valid,
    output logic [IDX_W-1:0] desc_len [2]
);

    logic [1:0]       valid_reg;
    logic [IDX_W-1:0] len_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (push_desc.valid)
                valid_reg[push_bank] <= 1'b1;
            // release the bank once its last beat is read out
            if (rel)
                valid_reg[rel_bank] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_desc.valid)
            len_reg[push_bank] <= push_desc.len;
    end

    assign desc_valid = valid_reg;
    assign desc_len   = len_reg;

endmodule

// ===== rtl/core/fsd_back.sv =====
// Back end: payload store, readout sequencer and output register.
// Depends on fsd_pkg.
module fsd_back
    import fsd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int AW           = $clog2(BUFFER_DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [AW:0]       wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic [1:0]        desc_valid,
    input  logic [IDX_W-1:0]  desc_len [2],
    output logic              rel,
    output logic              rel_bank,
    input  logic              pop,
    output logic              empty,
    output logic [BYTE_W-1:0] out_byte,
    output logic [IDX_W-1:0]  out_index,
    output logic [IDX_W-1:0]  frame_length,
    output logic              last,
    output logic              empty_frame
);

    logic [BYTE_W-1:0] mem [2**(AW+1)];
    logic [BYTE_W-1:0] rd_data_reg;

    logic             rd_bank_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg, pend_len_reg;
    logic             pend_last_reg, pend_empty_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [IDX_W-1:0]  out_idx_reg, out_len_reg;
    logic              out_last_reg, out_empty_reg;

    logic             issue, cap;
    logic [IDX_W-1:0] cur_len;
    logic             cur_empty, cur_last;

    assign cur_len   = desc_len[rd_bank_reg];
    assign cur_empty = (cur_len == '0);
    assign cur_last  = cur_empty || (IDX_W'(rd_idx_reg + 1'b1) == cur_len);
    assign cap       = pend_reg && (!out_valid_reg || pop);
    assign issue     = desc_valid[rd_bank_reg] && (!pend_reg || cap);
    assign rel       = issue && cur_last;
    assign rel_bank  = rd_bank_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (issue)
            rd_data_reg <= mem[{rd_bank_reg, rd_idx_reg[AW-1:0]}];
    end

    // read sequencer: advance through the frame, then move to the other bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_bank_reg <= 1'b0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                if (cur_last)
                begin
                    rd_bank_reg <= ~rd_bank_reg;
                    rd_idx_reg  <= '0;
                end
                else
                    rd_idx_reg <= IDX_W'(rd_idx_reg + 1'b1);
                pend_reg <= 1'b1;
            end
            else if (cap)
                pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_idx_reg   <= rd_idx_reg;
            pend_len_reg   <= cur_len;
            pend_last_reg  <= cur_last;
            pend_empty_reg <= cur_empty;
        end
        if (cap)
        begin
            out_byte_reg  <= pend_empty_reg ? '0 : rd_data_reg;
            out_idx_reg   <= pend_idx_reg;
            out_len_reg   <= pend_len_reg;
            out_last_reg  <= pend_last_reg;
            out_empty_reg <= pend_empty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cap)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_index    = out_idx_reg;
    assign frame_length = out_len_reg;
    assign last         = out_last_reg;
    assign empty_frame  = out_empty_reg;

endmodule

// ===== rtl/core/byte_stuffing_frame_decoder.sv =====
// Byte-stuffing frame decoder, top level. Depends on fsd_pkg, fsd_front, fsd_queue, fsd_back.
// Input: one byte per cycle; full rises only while both payload banks hold frames not yet read out.
// Output: one beat per cycle while pop takes them, set by the payload store's single read port;
// a frame's first beat passes queue valid, read data and output registers after its end flag.
// Reset (rst_n, async, active low): flags back to 0xF7/0x7F/0x7D, idle, no frames queued.
module byte_stuffing_frame_decoder
    import fsd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wdata,
    // received bytes
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] rx_byte,
    // decoded payload beats
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] out_byte,
    output logic [IDX_W-1:0]  out_index,
    output logic [IDX_W-1:0]  frame_length,
    output logic              last,
    output logic              empty_frame
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic              accept;
    logic              wr_bank;
    logic              wr_en;
    logic [AW:0]       wr_addr;
    logic [BYTE_W-1:0] wr_data;
    fsd_push_t         push_desc;
    logic              rel, rel_bank;
    logic [1:0]        desc_valid;
    logic [IDX_W-1:0]  desc_len [2];

    // The payload store is split in two banks. The front end fills one bank
    // while the back end reads out the other; hold input beats while the bank
    // the front end would write still holds a frame awaiting readout.
    assign full   = desc_valid[wr_bank];
    assign accept = push && !full;

    fsd_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .wr_bank   (wr_bank),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push_desc (push_desc)
    );

    // One descriptor per bank: frame length, valid until the last beat is read
    fsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_bank  (wr_bank),
        .push_desc  (push_desc),
        .rel        (rel),
        .rel_bank   (rel_bank),
        .desc_valid (desc_valid),
        .desc_len   (desc_len)
    );

    // Readout: registered memory read, then the output register
    fsd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .desc_valid   (desc_valid),
        .desc_len     (desc_len),
        .rel          (rel),
        .rel_bank     (rel_bank),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .out_index    (out_index),
        .frame_length (frame_length),
        .last         (last),
        .empty_frame  (empty_frame)
    );

endmodule
